// ===== sv/mcs_pkg.sv =====
// Package for the Morse character serializer: widths, ROM address types and the
// pattern ROM contents with the functions that build and address them.
// Has no dependencies; imported by morse_char_serializer.
package mcs_pkg;

  localparam int CharWidth   = 8;
  localparam int PatWidth    = 23;  // up to 22 elements plus the end marker
  localparam int NumEntries  = 42;
  localparam int AddrWidth   = 6;

  typedef logic [PatWidth-1:0]  pat_t;
  typedef logic [AddrWidth-1:0] rom_addr_t;

  // ROM layout: letters, then digits, then punctuation, then the word gap.
  localparam rom_addr_t IdxLetterA   = 6'd0;
  localparam rom_addr_t IdxDigit0    = 6'd26;
  localparam rom_addr_t IdxComma     = 6'd36;
  localparam rom_addr_t IdxPeriod    = 6'd37;
  localparam rom_addr_t IdxQuestion  = 6'd38;
  localparam rom_addr_t IdxSlash     = 6'd39;
  localparam rom_addr_t IdxApostr    = 6'd40;
  localparam rom_addr_t IdxWordGap   = 6'd41;

  // Word gap: four key-up elements, then the end marker.
  localparam pat_t WordGapPat = 23'h000010;

  // Expands a dot/dash code into its element word, least significant element
  // first. Bit i of sym is 1 when symbol i (sent i-th) is a dash. A dot is
  // one key-down element, a dash three, each followed by a key-up element;
  // two more key-up elements close the character, then the end marker.
  function automatic pat_t morse_word(input logic [2:0] len, input logic [5:0] sym);
    pat_t word;
    int   pos;
    word = '0;
    pos  = 0;
    for (int i = 0; i < 6; i++) begin
      if (i < int'(len)) begin
        if (sym[i]) begin
          word[pos]   = 1'b1;
          word[pos+1] = 1'b1;
          word[pos+2] = 1'b1;
          pos = pos + 4;
        end else begin
          word[pos] = 1'b1;
          pos = pos + 2;
        end
      end
    end
    pos = pos + 2;
    word[pos] = 1'b1;
    return word;
  endfunction

  localparam pat_t PatRom [NumEntries] = '{
    morse_word(3'd2, 6'b000010),  // A
    morse_word(3'd4, 6'b000001),  // B
    morse_word(3'd4, 6'b000101),  // C
    morse_word(3'd3, 6'b000001),  // D
    morse_word(3'd1, 6'b000000),  // E
    morse_word(3'd4, 6'b000100),  // F
    morse_word(3'd3, 6'b000011),  // G
    morse_word(3'd4, 6'b000000),  // H
    morse_word(3'd2, 6'b000000),  // I
    morse_word(3'd4, 6'b001110),  // J
    morse_word(3'd3, 6'b000101),  // K
    morse_word(3'd4, 6'b000010),  // L
    morse_word(3'd2, 6'b000011),  // M
    morse_word(3'd2, 6'b000001),  // N
    morse_word(3'd3, 6'b000111),  // O
    morse_word(3'd4, 6'b000110),  // P
    morse_word(3'd4, 6'b001011),  // Q
    morse_word(3'd3, 6'b000010),  // R
    morse_word(3'd3, 6'b000000),  // S
    morse_word(3'd1, 6'b000001),  // T
    morse_word(3'd3, 6'b000100),  // U
    morse_word(3'd4, 6'b001000),  // V
    morse_word(3'd3, 6'b000110),  // W
    morse_word(3'd4, 6'b001001),  // X
    morse_word(3'd4, 6'b001101),  // Y
    morse_word(3'd4, 6'b000011),  // Z
    morse_word(3'd5, 6'b011111),  // 0
    morse_word(3'd5, 6'b011110),  // 1
    morse_word(3'd5, 6'b011100),  // 2
    morse_word(3'd5, 6'b011000),  // 3
    morse_word(3'd5, 6'b010000),  // 4
    morse_word(3'd5, 6'b000000),  // 5
    morse_word(3'd5, 6'b000001),  // 6
    morse_word(3'd5, 6'b000011),  // 7
    morse_word(3'd5, 6'b000111),  // 8
    morse_word(3'd5, 6'b001111),  // 9
    morse_word(3'd6, 6'b110011),  // comma
    morse_word(3'd6, 6'b101010),  // period
    morse_word(3'd6, 6'b001100),  // question mark
    morse_word(3'd5, 6'b001001),  // slash
    morse_word(3'd6, 6'b011110),  // apostrophe
    WordGapPat                    // anything else
  };

  // Maps a character code to its ROM entry, folding lower case to upper.
  function automatic rom_addr_t char_index(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] off;
    rom_addr_t            idx;
    off = '0;
    idx = IdxWordGap;
    priority if (c == 8'd44) begin
      idx = IdxComma;
    end else if (c == 8'd46) begin
      idx = IdxPeriod;
    end else if (c == 8'd63) begin
      idx = IdxQuestion;
    end else if (c == 8'd47) begin
      idx = IdxSlash;
    end else if (c == 8'd39) begin
      idx = IdxApostr;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      off = c - 8'd48;
      idx = IdxDigit0 + off[AddrWidth-1:0];
    end else if (c >= 8'd65 && c <= 8'd90) begin
      off = c - 8'd65;
      idx = IdxLetterA + off[AddrWidth-1:0];
    end else if (c >= 8'd97 && c <= 8'd122) begin
      off = c - 8'd97;
      idx = IdxLetterA + off[AddrWidth-1:0];
    end else begin
      idx = IdxWordGap;
    end
    return idx;
  endfunction

endpackage

// ===== sv/morse_char_serializer.sv =====
// Sequence: the ROM word read for an accepted character is loaded into the shift
// register in LOAD, then its elements leave one per cycle while m_tready holds.
// A character carries 4 to 22 elements; s_tready stays low, so no new character is
// accepted, until the last element of the current one has been taken.
// Reset: rst is synchronous and active high; it returns the block to idle and
// drops any character in progress.
//
// Top level of the Morse character serializer. Depends on mcs_pkg for the
// pattern ROM, its address mapping and the pattern width.
module morse_char_serializer (
  input  logic       clk,
  input  logic       rst,
  // Input items: one character each.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  // Result items: one keying element each.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] key_level, [7:1] zero
  output logic       m_tlast    // last_element
);
  import mcs_pkg::*;

  // Control flow: IDLE takes a character and starts the ROM read, LOAD moves the
  // registered ROM word into the shift register, SEND offers one element per cycle
  // while m_tready holds, until only the end marker is left above bit 0.
  typedef enum logic [1:0] {
    IDLE,
    LOAD,
    SEND
  } state_t;

  state_t state;
  pat_t   rom_q;   // registered read data of the pattern ROM
  pat_t   shift;   // remaining elements, current one in bit 0, end marker above

  logic   in_fire;
  logic   out_fire;
  logic   is_last;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  // The element in bit 0 is the last one when only the end marker remains
  // above it.
  assign is_last  = (shift[PatWidth-1:1] == {{(PatWidth-2){1'b0}}, 1'b1});

  assign s_tready = (state == IDLE);
  assign m_tvalid = (state == SEND);
  assign m_tdata  = {7'b0, shift[0]};
  assign m_tlast  = is_last;

  // Pattern ROM: synchronous read, addressed straight from the accepted item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rom_q <= PatRom[char_index(s_tdata)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_fire) begin
            state <= LOAD;
          end
        end
        LOAD: begin
          shift <= rom_q;
          state <= SEND;
        end
        SEND: begin
          if (out_fire) begin
            shift <= {1'b0, shift[PatWidth-1:1]};
            if (is_last) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The end marker must never be shifted out while elements are offered.
  a_marker_present: assert property (@(posedge clk) disable iff (rst)
    (state == SEND) |-> (shift[PatWidth-1:1] != '0))
    else $error("end marker lost while sending");

  // An accepted character always leads to the ROM load cycle.
  a_accept_to_load: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == LOAD))
    else $error("accepted character did not start a load");

  // Element output continues until the last element is taken.
  a_send_continues: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !m_tlast) |=> m_tvalid)
    else $error("element stream ended before the last element");

  // After the last element the block is ready for the next character.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block not idle after the last element");
`endif

endmodule
